// File: design/rdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdn_pkg
// Types, constants and helpers shared by the root election node modules.
// ----------------------------------------------------------------------------
package rdn_pkg;

  localparam int unsigned N_PORTS_DEF     = 4;
  localparam int unsigned NUM_COST_REGS   = 4;
  localparam logic [2:0]  PORT_NONE       = 3'd4;
  localparam logic [31:0] RESET_NODE_ID   = 32'd0;
  localparam logic [31:0] RESET_TIMEOUT   = 32'd10000;
  localparam logic [31:0] RESET_HOP_COST  = 32'd1;

  typedef enum logic [1:0] {
    OP_MSG    = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_BUILD  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_NODE_ID     = 3'd0,
    CFG_ROOT_TMO    = 3'd1,
    CFG_COST_LINK0  = 3'd2,
    CFG_COST_LINK1  = 3'd3,
    CFG_COST_LINK2  = 3'd4,
    CFG_COST_LINK3  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] root_id;
    logic [31:0] root_cost;
    logic [2:0]  up_port;
    logic [31:0] up_node;
    logic [32:0] deadline;
    logic        deadline_inf;
  } state_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  link;
    logic        link_ok;
    logic [31:0] mroot;
    logic [31:0] cand;
    logic [31:0] sender;
    logic [32:0] fresh;
    logic [31:0] life;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic        changed;
    logic [31:0] root;
    logic [31:0] cost;
    logic [31:0] expiry;
    logic [2:0]  up_port;
    logic        is_root;
  } result_t;

  function automatic state_t own_root(logic [31:0] id);
    state_t s;
    s.root_id      = id;
    s.root_cost    = 32'd0;
    s.up_port      = PORT_NONE;
    s.up_node      = id;
    s.deadline     = 33'd0;
    s.deadline_inf = 1'b1;
    return s;
  endfunction

endpackage

// File: design/rdn_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdn_step
// Next root state and outgoing result for one staged item.
// ----------------------------------------------------------------------------
module rdn_step import rdn_pkg::*; (
  input  logic [31:0] node_id_i,
  input  logic [31:0] root_timeout_i,
  input  state_t      state_i,
  input  item_t       item_i,
  output state_t      state_o,
  output result_t     result_o
);

  state_t      st;
  logic        chg;
  logic        fresh_win;
  logic [32:0] now_x;
  logic [32:0] diff;
  logic [31:0] rem_old;
  logic [31:0] expiry;

  always_comb begin
    st        = state_i;
    chg       = 1'b0;
    fresh_win = 1'b0;
    unique case (item_i.op)
      OP_MSG: begin
        if (item_i.link_ok) begin
          if (item_i.mroot < state_i.root_id) begin
            st.root_id      = item_i.mroot;
            st.root_cost    = item_i.cand;
            st.up_port      = {1'b0, item_i.link};
            st.up_node      = item_i.sender;
            st.deadline     = item_i.fresh;
            st.deadline_inf = 1'b0;
            chg             = 1'b1;
            fresh_win       = 1'b1;
          end else if (item_i.mroot == state_i.root_id && state_i.root_id != node_id_i) begin
            if (!state_i.deadline_inf && item_i.fresh > state_i.deadline) begin
              st.deadline = item_i.fresh;
              fresh_win   = 1'b1;
            end
            if (item_i.sender == state_i.up_node) begin
              st.up_port = {1'b0, item_i.link};
              if (item_i.cand != state_i.root_cost) begin
                st.root_cost = item_i.cand;
                chg          = 1'b1;
              end
            end else if (item_i.cand < state_i.root_cost) begin
              st.root_cost = item_i.cand;
              st.up_port   = {1'b0, item_i.link};
              st.up_node   = item_i.sender;
              chg          = 1'b1;
            end
          end
        end
      end
      OP_EXPIRE: begin
        st  = own_root(node_id_i);
        chg = 1'b1;
      end
      OP_BUILD: begin
      end
      default: begin
      end
    endcase
  end

  assign now_x = {1'b0, item_i.now};
  assign diff  = state_i.deadline - now_x;

  always_comb begin
    if (state_i.deadline <= now_x) begin
      rem_old = 32'd0;
    end else if (diff[32]) begin
      rem_old = '1;
    end else begin
      rem_old = diff[31:0];
    end
  end

  always_comb begin
    if (st.root_id == node_id_i) begin
      expiry = root_timeout_i;
    end else if (st.deadline_inf) begin
      expiry = '1;
    end else if (fresh_win) begin
      expiry = item_i.life;
    end else begin
      expiry = rem_old;
    end
  end

  assign state_o          = st;
  assign result_o.changed = chg;
  assign result_o.root    = st.root_id;
  assign result_o.cost    = st.root_cost;
  assign result_o.expiry  = expiry;
  assign result_o.up_port = st.up_port;
  assign result_o.is_root = (st.root_id == node_id_i);

endmodule

// File: design/root_election_distance_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// root_election_distance_node
// One node of a root election with path costs: takes received messages,
// expire and build requests, and reports root, cost, lifetime and parent.
//
//   channel | direction | handshake             | beat
//   in      | in        | in_valid_i/in_ready_o   | operation + message fields
//   out     | out       | out_valid_o/out_ready_i | changed, root, cost, expiry
//   cfg     | in        | cfg_valid_i/cfg_ready_o | register index + data
//
// One beat per cycle sustained while result beats are taken; an input beat passes
// the input register, then the state update and result register.
// The root state register updates in the same cycle as its result register.
// Reset puts the node at its own root; no clearing pass is needed.
// A stalled result holds the staged beat; the input stays open while the
// staged slot is free or moving.
// ----------------------------------------------------------------------------
module root_election_distance_node import rdn_pkg::*; #(
  parameter int unsigned N_PORTS = N_PORTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  arrival_link_i,
  input  logic [31:0] msg_root_i,
  input  logic [31:0] msg_cost_i,
  input  logic [31:0] msg_sender_i,
  input  logic [31:0] msg_expiry_ms_i,
  input  logic [31:0] now_ms_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        changed_o,
  output logic [31:0] out_root_o,
  output logic [31:0] out_cost_o,
  output logic [31:0] out_expiry_ms_o,
  output logic [2:0]  out_parent_link_o,
  output logic        is_root_o
);

  logic [31:0] node_id_q;
  logic [31:0] timeout_q;
  logic [31:0] hop_cost_q [NUM_COST_REGS];

  state_t      state_q;
  state_t      state_next;
  item_t       item_d;
  item_t       item_q;
  logic        s1_valid_q;
  result_t     result_d;
  result_t     result_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= RESET_NODE_ID;
      timeout_q <= RESET_TIMEOUT;
      for (int i = 0; i < NUM_COST_REGS; i++) begin
        hop_cost_q[i] <= RESET_HOP_COST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_NODE_ID:    node_id_q     <= cfg_data_i;
        CFG_ROOT_TMO:   timeout_q     <= cfg_data_i;
        CFG_COST_LINK0: hop_cost_q[0] <= cfg_data_i;
        CFG_COST_LINK1: hop_cost_q[1] <= cfg_data_i;
        CFG_COST_LINK2: hop_cost_q[2] <= cfg_data_i;
        CFG_COST_LINK3: hop_cost_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // stage the beat: link cost sum and fresh deadline ahead of the state update
  always_comb begin
    item_d.op      = op_e'(operation_i);
    item_d.link    = arrival_link_i;
    item_d.link_ok = (int'(arrival_link_i) < N_PORTS);
    item_d.mroot   = msg_root_i;
    item_d.cand    = msg_cost_i + hop_cost_q[arrival_link_i];
    item_d.sender  = msg_sender_i;
    item_d.fresh   = {1'b0, now_ms_i} + {1'b0, msg_expiry_ms_i};
    item_d.life    = msg_expiry_ms_i;
    item_d.now     = now_ms_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  rdn_step u_step (
    .node_id_i      (node_id_q),
    .root_timeout_i (timeout_q),
    .state_i        (state_q),
    .item_i         (item_q),
    .state_o        (state_next),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= own_root(RESET_NODE_ID);
    end else if (cfg_we && cfg_index_i == CFG_NODE_ID) begin
      state_q <= own_root(cfg_data_i);
    end else if (fire) begin
      state_q <= state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign changed_o         = result_q.changed;
  assign out_root_o        = result_q.root;
  assign out_cost_o        = result_q.cost;
  assign out_expiry_ms_o   = result_q.expiry;
  assign out_parent_link_o = result_q.up_port;
  assign is_root_o         = result_q.is_root;

  a_root_no_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_root_o |-> out_parent_link_o == PORT_NONE && out_cost_o == 32'd0)
    else $error("self root beat carries a parent or a cost");

  a_parent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.up_port == PORT_NONE || int'(state_q.up_port) < N_PORTS)
    else $error("parent link outside the link range");

  a_expire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.op == OP_EXPIRE |=> out_valid_o && changed_o && is_root_o)
    else $error("expire did not return the node to its own root");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input blocked without a stalled result");

  a_root_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> is_root_o == (out_root_o == node_id_q))
    else $error("root flag disagrees with the reported root");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for root_election_distance_node. A clocked driver sends
// message, expire, build and unused-code beats from a pending queue. A clocked
// monitor compares each result beat with the oldest prediction from a model
// of the node kept in the bench. Registers are rewritten between phases
// while the node is idle. The phases cover extreme register values, random
// stalls on both sides, a long result hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module testbench import rdn_pkg::*; ();

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int unsigned STUCK_MAX = 3000;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PHASE_LEN = 112;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  link;
    logic [31:0] mroot;
    logic [31:0] mcost;
    logic [31:0] sender;
    logic [31:0] life;
    logic [31:0] now;
  } node_beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = '0;
  logic [31:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i     = '0;
  logic [1:0]  arrival_link_i  = '0;
  logic [31:0] msg_root_i      = '0;
  logic [31:0] msg_cost_i      = '0;
  logic [31:0] msg_sender_i    = '0;
  logic [31:0] msg_expiry_ms_i = '0;
  logic [31:0] now_ms_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        changed_o;
  logic [31:0] out_root_o;
  logic [31:0] out_cost_o;
  logic [31:0] out_expiry_ms_o;
  logic [2:0]  out_parent_link_o;
  logic        is_root_o;

  root_election_distance_node dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .arrival_link_i    (arrival_link_i),
    .msg_root_i        (msg_root_i),
    .msg_cost_i        (msg_cost_i),
    .msg_sender_i      (msg_sender_i),
    .msg_expiry_ms_i   (msg_expiry_ms_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .changed_o         (changed_o),
    .out_root_o        (out_root_o),
    .out_cost_o        (out_cost_o),
    .out_expiry_ms_o   (out_expiry_ms_o),
    .out_parent_link_o (out_parent_link_o),
    .is_root_o         (is_root_o)
  );

  // node model: registers and election state
  logic [31:0] node_id_reg;
  logic [31:0] timeout_reg;
  logic [31:0] hop_cost [NUM_COST_REGS];
  logic [31:0] root_now;
  logic [31:0] cost_now;
  logic [2:0]  up_port_now;
  logic [31:0] parent_now;
  logic [32:0] deadline_ms;
  logic        deadline_inf;

  node_beat_t  pending_beats [$];
  result_t     expected_results [$];
  node_beat_t  cur_beat;
  logic        in_beat_taken = 1'b0;
  logic        quiet         = 1'b0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  logic [31:0] root_pool [4];
  logic [31:0] sender_pool [4];
  logic [31:0] clock_ms;

  function automatic void rejoin_self();
    root_now     = node_id_reg;
    cost_now     = '0;
    up_port_now  = PORT_NONE;
    parent_now   = node_id_reg;
    deadline_ms  = '0;
    deadline_inf = 1'b1;
  endfunction

  function automatic logic [31:0] life_left(logic [31:0] now);
    logic [32:0] rem;
    if (root_now == node_id_reg) return timeout_reg;
    if (deadline_inf) return '1;
    if (deadline_ms <= {1'b0, now}) return '0;
    rem = deadline_ms - {1'b0, now};
    return rem[32] ? '1 : rem[31:0];
  endfunction

  function automatic result_t elect_step(node_beat_t b);
    result_t     r;
    logic [31:0] cand;
    logic [32:0] fresh;
    logic        chg;
    chg   = 1'b0;
    cand  = b.mcost + hop_cost[b.link];
    fresh = {1'b0, b.now} + {1'b0, b.life};
    if (b.op == OP_MSG && b.link < N_PORTS_DEF) begin
      if (b.mroot < root_now) begin
        root_now     = b.mroot;
        cost_now     = cand;
        up_port_now  = {1'b0, b.link};
        parent_now   = b.sender;
        deadline_ms  = fresh;
        deadline_inf = 1'b0;
        chg          = 1'b1;
      end else if (b.mroot == root_now && root_now != node_id_reg) begin
        if (!deadline_inf && fresh > deadline_ms) deadline_ms = fresh;
        if (b.sender == parent_now) begin
          up_port_now = {1'b0, b.link};
          if (cand != cost_now) begin
            cost_now = cand;
            chg      = 1'b1;
          end
        end else if (cand < cost_now) begin
          cost_now    = cand;
          up_port_now = {1'b0, b.link};
          parent_now  = b.sender;
          chg         = 1'b1;
        end
      end
    end else if (b.op == OP_EXPIRE) begin
      rejoin_self();
      chg = 1'b1;
    end
    r.changed = chg;
    r.root    = root_now;
    r.cost    = cost_now;
    r.expiry  = life_left(b.now);
    r.up_port = up_port_now;
    r.is_root = (root_now == node_id_reg);
    return r;
  endfunction

  function automatic node_beat_t mk_beat(logic [1:0] op, logic [1:0] link,
                                         logic [31:0] mroot, logic [31:0] mcost,
                                         logic [31:0] sender, logic [31:0] life,
                                         logic [31:0] now);
    node_beat_t b;
    b.op     = op;
    b.link   = link;
    b.mroot  = mroot;
    b.mcost  = mcost;
    b.sender = sender;
    b.life   = life;
    b.now    = now;
    return b;
  endfunction

  function automatic node_beat_t random_beat();
    node_beat_t  b;
    int unsigned pick;
    pick     = $urandom_range(99);
    b.op     = OP_MSG;
    b.link   = 2'($urandom_range(3));
    b.mroot  = root_pool[$urandom_range(3)];
    b.sender = sender_pool[$urandom_range(3)];
    b.mcost  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
    b.life   = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
    clock_ms = clock_ms + $urandom_range(200);
    b.now    = ($urandom_range(19) == 0) ? $urandom : clock_ms;
    if (pick < 8) begin
      b.op = OP_EXPIRE;
    end else if (pick < 22) begin
      b.op = OP_BUILD;
    end else if (pick < 25) begin
      b.op = OP_UNUSED;
    end else if (pick < 30) begin
      b.mroot  = $urandom;
      b.sender = $urandom;
      b.mcost  = $urandom;
    end
    return b;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NODE_ID: begin
        node_id_reg = data;
        rejoin_self();
      end
      CFG_ROOT_TMO:   timeout_reg = data;
      CFG_COST_LINK0: hop_cost[0] = data;
      CFG_COST_LINK1: hop_cost[1] = data;
      CFG_COST_LINK2: hop_cost[2] = data;
      CFG_COST_LINK3: hop_cost[3] = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (pending_beats.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
        cur_beat = pending_beats.pop_front();
        operation_i     <= cur_beat.op;
        arrival_link_i  <= cur_beat.link;
        msg_root_i      <= cur_beat.mroot;
        msg_cost_i      <= cur_beat.mcost;
        msg_sender_i    <= cur_beat.sender;
        msg_expiry_ms_i <= cur_beat.life;
        now_ms_i        <= cur_beat.now;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  // monitor and prediction
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("changed", 32'(exp_r.changed), 32'(changed_o));
          check_field("out_root", exp_r.root, out_root_o);
          check_field("out_cost", exp_r.cost, out_cost_o);
          check_field("out_expiry_ms", exp_r.expiry, out_expiry_ms_o);
          check_field("out_parent_link", 32'(exp_r.up_port), 32'(out_parent_link_o));
          check_field("is_root", 32'(exp_r.is_root), 32'(is_root_o));
        end
      end
      in_beat_taken = in_valid_i && in_ready_o;
      if (in_beat_taken)
        expected_results.push_back(elect_step(mk_beat(operation_i, arrival_link_i,
          msg_root_i, msg_cost_i, msg_sender_i, msg_expiry_ms_i, now_ms_i)));
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        stuck = 0;
      else
        stuck++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] nid;
    logic [31:0] tmo;
    logic [31:0] costs [NUM_COST_REGS];
    node_id_reg = RESET_NODE_ID;
    timeout_reg = RESET_TIMEOUT;
    for (int i = 0; i < NUM_COST_REGS; i++) hop_cost[i] = RESET_HOP_COST;
    rejoin_self();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(CFG_NODE_ID, 32'h0000_1000);
    cfg_write(CFG_ROOT_TMO, 32'd10000);
    cfg_write(CFG_COST_LINK0, 32'd1);
    cfg_write(CFG_COST_LINK1, 32'd2);
    cfg_write(CFG_COST_LINK2, 32'd3);
    cfg_write(CFG_COST_LINK3, 32'hFFFF_FFFF);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    // adopt, refresh, follow parent, cheaper path, wrap and saturation
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, '0));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd1, 32'h800, 32'd5, 32'hA, 32'd100, 32'd0));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, 32'd50));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, 32'd200));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd2, 32'h800, 32'd9, 32'hA, 32'd500, 32'd100));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd1, 32'h800, 32'd100, 32'hB, 32'd10, 32'd100));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd0, 32'h800, 32'd0, 32'hB, 32'd10, 32'd120));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd3, 32'h900, 32'd0, 32'hC, 32'd10, 32'd130));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, 32'd300));
    pending_beats.push_back(mk_beat(OP_UNUSED, 2'd3, '1, '1, '1, '1, 32'd310));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd0, 32'h800, 32'd0, 32'hB, '1, '1));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, '0));
    pending_beats.push_back(mk_beat(OP_EXPIRE, 2'd0, '0, '0, '0, '0, 32'd400));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd2, '1, '0, '1, '0, 32'd410));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd3, '0, '1, '1, '1, '1));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, '1));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd3, '0, '0, 32'h5, '0, '1));
    pending_beats.push_back(mk_beat(OP_EXPIRE, 2'd3, '1, '1, '1, '1, '1));
    pending_beats.push_back(mk_beat(OP_MSG, 2'd1, 32'h1000, 32'd0, 32'hD, 32'd5, 32'd0));
    pending_beats.push_back(mk_beat(OP_BUILD, 2'd0, '0, '0, '0, '0, 32'd1000));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      nid = (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFF_FFFF : $urandom;
      tmo = (p == 3) ? 32'd0 : (p == 4) ? 32'hFFFF_FFFF : $urandom_range(20000);
      for (int i = 0; i < NUM_COST_REGS; i++) begin
        if (p == 5)      costs[i] = '0;
        else if (p == 6) costs[i] = '1;
        else             costs[i] = ($urandom_range(7) == 0) ? $urandom : $urandom_range(50);
      end
      cfg_write(CFG_NODE_ID, nid);
      cfg_write(CFG_ROOT_TMO, tmo);
      cfg_write(CFG_COST_LINK0, costs[0]);
      cfg_write(CFG_COST_LINK1, costs[1]);
      cfg_write(CFG_COST_LINK2, costs[2]);
      cfg_write(CFG_COST_LINK3, costs[3]);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);

      root_pool[0]   = nid;
      root_pool[1]   = nid - 32'd1 - $urandom_range(3);
      root_pool[2]   = nid - 32'd100 - $urandom_range(50);
      root_pool[3]   = $urandom;
      sender_pool[0] = $urandom;
      sender_pool[1] = $urandom;
      sender_pool[2] = $urandom_range(15);
      sender_pool[3] = nid;
      clock_ms       = (p == 7) ? 32'hFFFF_F000 : $urandom_range(1000);
      quiet          = (p == 3);
      for (int n = 0; n < PHASE_LEN; n++) pending_beats.push_back(random_beat());
      if (p == 2) hold_req = 1'b1;
      drain();
      quiet = 1'b0;
    end

    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: sim.f
design/rdn_pkg.sv
design/rdn_step.sv
design/root_election_distance_node.sv
test/testbench.sv
